// ===== src/dense_layer_fast_sigmoid_train_core_defines.svh =====
// Assertion macros used by the core's datapath module.
`ifndef DENSE_LAYER_FAST_SIGMOID_TRAIN_CORE_DEFINES_SVH
`define DENSE_LAYER_FAST_SIGMOID_TRAIN_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLFS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, checked outside reset.
`define DLFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== src/dlfs_pkg.sv =====
package dlfs_pkg;

  localparam logic [2:0] OP_WR_W  = 3'd0;
  localparam logic [2:0] OP_INPUT = 3'd1;
  localparam logic [2:0] OP_GRAD  = 3'd2;
  localparam logic [2:0] OP_RD_W  = 3'd3;
  localparam logic [2:0] OP_RD_B  = 3'd4;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_LR   = 1'b1;

  localparam logic       MODE_RESET = 1'b1;
  localparam logic [15:0] LR_RESET  = 16'd655;

  localparam int ACC_W = 40;
  localparam int DIV_W = 48;

  typedef struct packed {
    logic capture;
    logic wr_w_item;
    logic wr_x_item;
    logic cnt_clr;
    logic row_item;
    logic col_item;
    logic bias_init;
    logic mac;
    logic div_init;
    logic div_step;
    logic fwd_load;
    logic rb_w_load;
    logic rb_b_load;
    logic m1_load;
    logic p_load;
    logic w_upd;
    logic b_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       last;
    logic       row_ok;
    logic       col_last;
    logic       row_last;
    logic       div_last;
    logic       out_free;
  } dp_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== src/dense_layer_fast_sigmoid_train_core.sv =====
// Channel   Handshake               Payload
// input     in_valid / in_stall     op, row, col, value, last
// output    out_valid / out_stall   kind, out_index, activation, derivative, end_of_run
// config    cfg_we                  cfg_index, cfg_data
//
// Writes and ignored ops return to idle after decode; weight or bias reads wait for a free output.
// A gradient reads, multiplies and writes back each column through the single weight memory port.
// The request marked last runs the forward pass over every row: one shared MAC
// walks each row, then an 8-step restoring divider forms the sigmoid.
// Reset (rst, synchronous) clears control and valid bits; weights need writing first.
// A held output stalls only the result load; in_stall is high while a request is busy.
module dense_layer_fast_sigmoid_train_core
  import dlfs_pkg::*;
#(
  parameter int IN_SIZE  = 16,
  parameter int OUT_SIZE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [15:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [3:0]         out_index,
  output logic signed [15:0] activation,
  output logic signed [15:0] derivative,
  output logic               end_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dlfs_dp #(
    .IN_SIZE  (IN_SIZE),
    .OUT_SIZE (OUT_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .row        (row),
    .col        (col),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_index  (out_index),
    .activation (activation),
    .derivative (derivative),
    .end_of_run (end_of_run)
  );

endmodule

// ===== src/dlfs_ctrl.sv =====
module dlfs_ctrl
  import dlfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DEC    = 5'd1;
  localparam logic [4:0] ST_FBRD   = 5'd2;
  localparam logic [4:0] ST_FBINIT = 5'd3;
  localparam logic [4:0] ST_FRD    = 5'd4;
  localparam logic [4:0] ST_FMAC   = 5'd5;
  localparam logic [4:0] ST_DINIT  = 5'd6;
  localparam logic [4:0] ST_DIV    = 5'd7;
  localparam logic [4:0] ST_FOUT   = 5'd8;
  localparam logic [4:0] ST_GMUL1  = 5'd9;
  localparam logic [4:0] ST_GRD    = 5'd10;
  localparam logic [4:0] ST_GMUL   = 5'd11;
  localparam logic [4:0] ST_GWR    = 5'd12;
  localparam logic [4:0] ST_GBRD   = 5'd13;
  localparam logic [4:0] ST_GBWR   = 5'd14;
  localparam logic [4:0] ST_RW     = 5'd15;
  localparam logic [4:0] ST_RB     = 5'd16;

  logic [4:0] state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.cnt_clr = 1'b1;
        cmd.row_item = 1'b1;
        cmd.col_item = 1'b1;
        case (stat.op)
          OP_WR_W: begin
            cmd.wr_w_item = 1'b1;
            state_next = ST_IDLE;
          end
          OP_INPUT: begin
            cmd.wr_x_item = 1'b1;
            state_next = stat.last ? ST_FBRD : ST_IDLE;
          end
          OP_GRAD: state_next = stat.row_ok ? ST_GMUL1 : ST_IDLE;
          OP_RD_W: state_next = ST_RW;
          OP_RD_B: state_next = ST_RB;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_FBRD: state_next = ST_FBINIT;
      ST_FBINIT: begin
        cmd.bias_init = 1'b1;
        state_next = ST_FRD;
      end
      ST_FRD: state_next = ST_FMAC;
      ST_FMAC: begin
        cmd.mac = 1'b1;
        state_next = stat.col_last ? ST_DINIT : ST_FRD;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_FOUT;
      end
      ST_FOUT: begin
        if (stat.out_free) begin
          cmd.fwd_load = 1'b1;
          state_next = stat.row_last ? ST_IDLE : ST_FBRD;
        end
      end
      ST_GMUL1: begin
        cmd.row_item = 1'b1;
        cmd.m1_load = 1'b1;
        state_next = ST_GRD;
      end
      ST_GRD: begin
        cmd.row_item = 1'b1;
        state_next = ST_GMUL;
      end
      ST_GMUL: begin
        cmd.row_item = 1'b1;
        cmd.p_load = 1'b1;
        state_next = ST_GWR;
      end
      ST_GWR: begin
        cmd.row_item = 1'b1;
        cmd.w_upd = 1'b1;
        state_next = stat.col_last ? ST_GBRD : ST_GRD;
      end
      ST_GBRD: begin
        cmd.row_item = 1'b1;
        state_next = ST_GBWR;
      end
      ST_GBWR: begin
        cmd.row_item = 1'b1;
        cmd.b_upd = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RW: begin
        cmd.row_item = 1'b1;
        cmd.col_item = 1'b1;
        if (stat.out_free) begin
          cmd.rb_w_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RB: begin
        cmd.row_item = 1'b1;
        cmd.col_item = 1'b1;
        if (stat.out_free) begin
          cmd.rb_b_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/dlfs_dp.sv =====
`include "dense_layer_fast_sigmoid_train_core_defines.svh"

module dlfs_dp
  import dlfs_pkg::*;
#(
  parameter int IN_SIZE  = 16,
  parameter int OUT_SIZE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         op,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [15:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [3:0]         out_index,
  output logic signed [15:0] activation,
  output logic signed [15:0] derivative,
  output logic               end_of_run
);

  localparam int RW    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
  localparam int CW    = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int DEPTH = OUT_SIZE * IN_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration.
  logic        act_mode;
  logic [15:0] lr;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode <= MODE_RESET;
      lr <= LR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) act_mode <= cfg_data[0];
      else lr <= cfg_data;
    end
  end

  // Captured request.
  logic [2:0]         it_op;
  logic               it_last;
  logic [3:0]         it_row, it_col;
  logic signed [15:0] it_val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_op <= op;
      it_last <= last;
      it_row <= row;
      it_col <= col;
      it_val <= value;
    end
  end

  logic row_ok, col_ok;
  assign row_ok = ({28'd0, it_row} < 32'(OUT_SIZE));
  assign col_ok = ({28'd0, it_col} < 32'(IN_SIZE));

  // Loop counters.
  logic [RW-1:0] r_cnt;
  logic [CW-1:0] c_cnt;
  logic          row_last, col_last;

  assign row_last = (r_cnt == RW'(OUT_SIZE - 1));
  assign col_last = (c_cnt == CW'(IN_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else begin
      if (cmd.mac || cmd.w_upd) c_cnt <= col_last ? '0 : c_cnt + 1'b1;
      if (cmd.fwd_load) r_cnt <= row_last ? '0 : r_cnt + 1'b1;
    end
  end

  logic [RW-1:0] rsel;
  logic [CW-1:0] csel;
  logic [AW-1:0] w_addr;

  assign rsel = cmd.row_item ? RW'(it_row) : r_cnt;
  assign csel = cmd.col_item ? CW'(it_col) : c_cnt;
  assign w_addr = AW'(AW'(rsel) * AW'(IN_SIZE) + AW'(csel));

  // Weight memory, one shared port.
  logic signed [15:0] weight_mem [DEPTH];
  logic signed [15:0] w_rdata, w_wdata, w_hold;
  logic               w_we;

  assign w_we = (cmd.wr_w_item && row_ok && col_ok) || cmd.w_upd;

  always_ff @(posedge clk) begin
    if (w_we) weight_mem[w_addr] <= w_wdata;
    w_rdata <= weight_mem[w_addr];
  end

  // Input memory; entries read as zero until written.
  logic signed [15:0] input_mem [IN_SIZE];
  logic [IN_SIZE-1:0] x_vld;
  logic signed [15:0] x_rdata, x_val;
  logic               x_vld_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_x_item && col_ok) input_mem[CW'(it_col)] <= it_val;
    x_rdata <= input_mem[csel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= '0;
      x_vld_q <= 1'b0;
    end else begin
      if (cmd.wr_x_item && col_ok) x_vld[CW'(it_col)] <= 1'b1;
      x_vld_q <= x_vld[csel];
    end
  end

  assign x_val = x_vld_q ? x_rdata : 16'sd0;

  // Bias memory; entries read as zero until written.
  logic signed [15:0] bias_mem [OUT_SIZE];
  logic [OUT_SIZE-1:0] b_vld;
  logic signed [15:0] b_rdata, b_cur, b_new;
  logic               b_vld_q;

  always_ff @(posedge clk) begin
    if (cmd.b_upd) bias_mem[rsel] <= b_new;
    b_rdata <= bias_mem[rsel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= '0;
      b_vld_q <= 1'b0;
    end else begin
      if (cmd.b_upd) b_vld[rsel] <= 1'b1;
      b_vld_q <= b_vld[rsel];
    end
  end

  assign b_cur = b_vld_q ? b_rdata : 16'sd0;

  // Forward accumulation.
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      mac_prod;

  assign mac_prod = w_rdata * x_val;

  always_ff @(posedge clk) begin
    if (cmd.bias_init) acc <= {{(ACC_W - 24){b_cur[15]}}, b_cur, 8'd0};
    else if (cmd.mac) acc <= acc + ACC_W'(mac_prod);
  end

  // Restoring divider for q = round(128*|z| / (65536 + |z|)); q never exceeds 128.
  logic [ACC_W-1:0] mag;
  logic [ACC_W:0]   dsum;
  logic [DIV_W-1:0] num, den;
  logic [7:0]       quo;
  logic [2:0]       dcnt;
  logic             zneg;

  assign mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign dsum = (ACC_W + 1)'(mag) + (ACC_W + 1)'(65536);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num <= DIV_W'({mag, 7'd0}) + DIV_W'(dsum >> 1);
      den <= DIV_W'({dsum, 7'd0});
      quo <= '0;
      dcnt <= 3'd7;
      zneg <= acc[ACC_W-1];
    end else if (cmd.div_step) begin
      if (num >= den) begin
        num <= num - den;
        quo <= {quo[6:0], 1'b1};
      end else begin
        quo <= {quo[6:0], 1'b0};
      end
      den <= den >> 1;
      dcnt <= dcnt - 1'b1;
    end
  end

  // Activation and derivative.
  logic [8:0]              sig_a;
  logic [17:0]             sig_pp;
  logic [17:0]             sig_da;
  logic signed [ACC_W-1:0] id_t;
  logic signed [15:0]      fwd_act, fwd_der;

  assign sig_a  = zneg ? (9'd128 - {1'b0, quo}) : (9'd128 + {1'b0, quo});
  assign sig_pp = 18'(sig_a) * 18'(9'd256 - sig_a);
  assign sig_da = (sig_pp + 18'd128) >> 8;
  assign id_t   = (acc + ACC_W'(128)) >>> 8;

  always_comb begin
    if (act_mode) begin
      fwd_act = $signed({7'd0, sig_a});
      fwd_der = $signed(sig_da[15:0]);
    end else begin
      if (id_t > ACC_W'(32767)) fwd_act = 16'sh7fff;
      else if (id_t < -ACC_W'(32768)) fwd_act = 16'sh8000;
      else fwd_act = id_t[15:0];
      fwd_der = 16'sd0;
    end
  end

  // Gradient step: m1 = lr*dz, then p = m1*x for each column.
  logic signed [32:0] m1, m1_t;
  logic signed [48:0] p, p_t;
  logic signed [24:0] w_dec;
  logic signed [16:0] b_dec;

  always_ff @(posedge clk) begin
    if (cmd.m1_load) m1 <= $signed({1'b0, lr}) * it_val;
    if (cmd.p_load) begin
      p <= m1 * x_val;
      w_hold <= w_rdata;
    end
  end

  assign p_t   = p + (49'sd1 <<< 23);
  assign w_dec = $signed(p_t[48:24]);
  assign m1_t  = m1 + (33'sd1 <<< 15);
  assign b_dec = $signed(m1_t[32:16]);
  assign b_new = sat16(32'(b_cur) - 32'(b_dec));
  assign w_wdata = cmd.w_upd ? sat16(32'(w_hold) - 32'(w_dec)) : it_val;

  // Output register.
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fwd_load || cmd.rb_w_load || cmd.rb_b_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_load) begin
      kind <= 1'b0;
      out_index <= 4'(r_cnt);
      activation <= fwd_act;
      derivative <= fwd_der;
      end_of_run <= row_last;
    end else if (cmd.rb_w_load || cmd.rb_b_load) begin
      kind <= 1'b1;
      out_index <= it_row;
      derivative <= 16'sd0;
      end_of_run <= 1'b1;
      if (cmd.rb_w_load) activation <= (row_ok && col_ok) ? w_rdata : 16'sd0;
      else activation <= row_ok ? b_cur : 16'sd0;
    end
  end

  assign stat.op       = it_op;
  assign stat.last     = it_last;
  assign stat.row_ok   = row_ok;
  assign stat.col_last = col_last;
  assign stat.row_last = row_last;
  assign stat.div_last = (dcnt == 3'd0);
  assign stat.out_free = out_free;

  `DLFS_ASSERT_SAME(a_load_free, cmd.fwd_load || cmd.rb_w_load || cmd.rb_b_load, out_free)
  `DLFS_ASSERT_SAME(a_grad_row, cmd.w_upd || cmd.b_upd, row_ok)
  `DLFS_ASSERT_NEXT(a_sig_range, cmd.fwd_load && act_mode, activation >= 16'sd0 && activation <= 16'sd256)
  `DLFS_ASSERT_NEXT(a_row_wrap, cmd.fwd_load && row_last, r_cnt == '0)

endmodule

// ===== verif/tb_dense_layer_fast_sigmoid_train_core.sv =====
`timescale 1ns / 100ps

module tb_dense_layer_fast_sigmoid_train_core;
  import dlfs_pkg::*;

  localparam int NIN  = 16;
  localparam int NOUT = 16;
  localparam int RANDOM_ITEMS = 230;
  // A gradient gives no result; this idle wait is long enough for it to finish.
  localparam int IDLE_CYCLES = 80;

  typedef struct {
    logic               kind;
    logic [3:0]         index;
    logic signed [15:0] act;
    logic signed [15:0] der;
    logic               eor;
  } layer_result_t;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
    bit                 typed;
    logic signed [15:0] typed_act;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         op;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [15:0] value;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic               kind;
  logic [3:0]         out_index;
  logic signed [15:0] activation;
  logic signed [15:0] derivative;
  logic               end_of_run;

  // Predictor copy of the layer state.
  logic signed [15:0] w_mem [NOUT*NIN];
  logic signed [15:0] b_mem [NOUT];
  logic signed [15:0] x_mem [NIN];
  logic               mode_q;
  logic [15:0]        lr_q;

  layer_result_t expected_results[$];
  int  error_count;
  bit  quiet;
  int  stall_left;

  dense_layer_fast_sigmoid_train_core #(.IN_SIZE(NIN), .OUT_SIZE(NOUT)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .row(row), .col(col),
    .value(value), .last(last), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .out_index(out_index), .activation(activation),
    .derivative(derivative), .end_of_run(end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_dense_layer_fast_sigmoid_train_core: errors");
    $finish;
  end

  function automatic logic signed [15:0] sat_q88(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint round_down_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic void push_result(logic k, logic [3:0] idx, logic signed [15:0] a,
                                      logic signed [15:0] d, logic e);
    layer_result_t r;
    r.kind = k; r.index = idx; r.act = a; r.der = d; r.eor = e;
    expected_results.push_back(r);
  endfunction

  function automatic void forward_pass();
    longint z, mag, dv, q, a, da;
    for (int r = 0; r < NOUT; r++) begin
      z = longint'(b_mem[r]) * 256;
      for (int c = 0; c < NIN; c++)
        z += longint'(w_mem[r*NIN + c]) * longint'(x_mem[c]);
      if (mode_q) begin
        mag = (z < 0) ? -z : z;
        dv = 65536 + mag;
        q = (128 * mag + dv / 2) / dv;
        a = 128 + ((z < 0) ? -q : q);
        da = (a * (256 - a) + 128) / 256;
      end else begin
        a = sat_q88(round_down_shift(z, 8));
        da = 0;
      end
      push_result(1'b0, r[3:0], a[15:0], da[15:0], r == NOUT - 1);
    end
  endfunction

  function automatic void layer_predict(logic [2:0] o, logic [3:0] r, logic [3:0] c,
                                        logic signed [15:0] v, logic l);
    longint p;
    case (o)
      OP_WR_W: w_mem[r*NIN + c] = v;
      OP_INPUT: begin
        x_mem[c] = v;
        if (l) forward_pass();
      end
      OP_GRAD: begin
        for (int k = 0; k < NIN; k++) begin
          p = longint'(lr_q) * longint'(v) * longint'(x_mem[k]);
          w_mem[r*NIN + k] = sat_q88(longint'(w_mem[r*NIN + k]) - round_down_shift(p, 24));
        end
        b_mem[r] = sat_q88(longint'(b_mem[r]) -
                           round_down_shift(longint'(lr_q) * longint'(v), 16));
      end
      OP_RD_W: push_result(1'b1, r, w_mem[r*NIN + c], 16'sd0, 1'b1);
      OP_RD_B: push_result(1'b1, r, b_mem[r], 16'sd0, 1'b1);
      default: ;
    endcase
  endfunction

  // Drives one request and holds it until accepted; typed rows override the prediction.
  task automatic send_request(logic [2:0] o, logic [3:0] r, logic [3:0] c,
                              logic signed [15:0] v, logic l, bit typed = 0,
                              logic signed [15:0] typed_act = 0);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o; row <= r; col <= c; value <= v; last <= l;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (typed) begin
      layer_predict(o, r, c, v, l);
      void'(expected_results.pop_back());
      push_result(1'b1, r, typed_act, 16'sd0, 1'b1);
    end else begin
      layer_predict(o, r, c, v, l);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) mode_q = data[0];
    else lr_q = data;
  endtask

  function automatic logic signed [15:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return 16'($urandom());
      default: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
    endcase
  endfunction

  // Receiver stall bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    layer_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result index %0d", out_index);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, kind); error_count++;
        end
        if (out_index !== e.index) begin
          $error("out_index expected %0d actual %0d", e.index, out_index); error_count++;
        end
        if (activation !== e.act) begin
          $error("activation expected %0d actual %0d", e.act, activation); error_count++;
        end
        if (derivative !== e.der) begin
          $error("derivative expected %0d actual %0d", e.der, derivative); error_count++;
        end
        if (end_of_run !== e.eor) begin
          $error("end_of_run expected %0d actual %0d", e.eor, end_of_run); error_count++;
        end
      end
    end
  end

  stim_row_t directed[$];
  logic signed [15:0] wv;
  int sent;
  int n_el;
  int pick;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_MODE; cfg_data = '0;
    in_valid = 1'b0; op = OP_WR_W; row = '0; col = '0; value = '0; last = 1'b0;
    out_stall = 1'b0;
    stall_left = 0; error_count = 0; quiet = 0;
    for (int i = 0; i < NOUT*NIN; i++) w_mem[i] = '0;
    for (int i = 0; i < NOUT; i++) b_mem[i] = '0;
    for (int i = 0; i < NIN; i++) x_mem[i] = '0;
    mode_q = MODE_RESET;
    lr_q = LR_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every weight is written before any read or forward pass can touch it.
    for (int r = 0; r < NOUT; r++)
      for (int c = 0; c < NIN; c++) begin
        if (r == 0 && c == 0) wv = 16'sh7fff;
        else if (r == NOUT - 1 && c == NIN - 1) wv = 16'sh8000;
        else wv = rand_q88();
        send_request(OP_WR_W, 4'(r), 4'(c), wv, 1'b0);
      end

    directed = '{
      '{OP_RD_W,  4'd0,  4'd0,  16'sd0,     1'b0, 1, 16'sh7fff},
      '{OP_RD_W,  4'd15, 4'd15, 16'sd0,     1'b1, 1, 16'sh8000},
      '{OP_RD_B,  4'd0,  4'd0,  16'sd0,     1'b0, 1, 16'sd0},
      '{OP_RD_B,  4'd15, 4'd9,  16'sd0,     1'b1, 1, 16'sd0},
      '{3'd5,     4'd3,  4'd3,  16'sh7fff,  1'b1, 0, 16'sd0},
      '{3'd6,     4'd15, 4'd15, 16'sh8000,  1'b0, 0, 16'sd0},
      '{3'd7,     4'd0,  4'd0,  16'sd1,     1'b1, 0, 16'sd0},
      '{OP_WR_W,  4'd1,  4'd2,  16'sd300,   1'b1, 0, 16'sd0},
      '{OP_INPUT, 4'd0,  4'd0,  16'sh7fff,  1'b0, 0, 16'sd0},
      '{OP_INPUT, 4'd5,  4'd15, 16'sh8000,  1'b1, 0, 16'sd0},
      '{OP_GRAD,  4'd0,  4'd0,  16'sh8000,  1'b1, 0, 16'sd0},
      '{OP_GRAD,  4'd15, 4'd7,  16'sh7fff,  1'b0, 0, 16'sd0},
      '{OP_RD_B,  4'd0,  4'd0,  16'sd0,     1'b0, 0, 16'sd0},
      '{OP_RD_B,  4'd15, 4'd0,  16'sd0,     1'b0, 0, 16'sd0},
      '{OP_RD_W,  4'd0,  4'd15, 16'sd0,     1'b0, 0, 16'sd0},
      '{OP_INPUT, 4'd0,  4'd3,  16'sd0,     1'b1, 0, 16'sd0},
      '{OP_GRAD,  4'd7,  4'd0,  16'sd0,     1'b0, 0, 16'sd0},
      '{OP_INPUT, 4'd0,  4'd1,  16'sd256,   1'b1, 0, 16'sd0}
    };
    foreach (directed[i])
      send_request(directed[i].op, directed[i].row, directed[i].col, directed[i].value,
                   directed[i].last, directed[i].typed, directed[i].typed_act);

    // Random part in phases; each boundary lets the block go fully idle first.
    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      drain_and_settle();
      case (phase)
        0: begin write_register(CFG_MODE, 16'd0); write_register(CFG_LR, 16'd0); end
        1: begin write_register(CFG_MODE, 16'd1); write_register(CFG_LR, 16'hffff); end
        2: begin write_register(CFG_MODE, 16'd0); write_register(CFG_LR, 16'($urandom())); end
        3: begin write_register(CFG_MODE, 16'd1); write_register(CFG_LR, LR_RESET); end
        default: begin
          write_register(CFG_MODE, 16'($urandom_range(0, 1)));
          write_register(CFG_LR, 16'($urandom_range(0, 4000)));
          quiet = 1;
        end
      endcase
      while (sent < RANDOM_ITEMS * (phase + 1) / 5) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // A run of input writes ending in last, the usual way to start a pass; only a run of NIN covers every column.
          n_el = $urandom_range(1, NIN);
          for (int k = 0; k < n_el; k++)
            send_request(OP_INPUT, 4'($urandom()), 4'((n_el == NIN) ? k : $urandom()),
                         rand_q88(), k == n_el - 1);
          sent += n_el;
        end else begin
          if (pick < 62) send_request(OP_GRAD, 4'($urandom()), 4'($urandom()), rand_q88(),
                                      1'($urandom()));
          else if (pick < 75) send_request(OP_RD_W, 4'($urandom()), 4'($urandom()),
                                           16'($urandom()), 1'($urandom()));
          else if (pick < 85) send_request(OP_RD_B, 4'($urandom()), 4'($urandom()),
                                           16'($urandom()), 1'($urandom()));
          else if (pick < 93) send_request(OP_WR_W, 4'($urandom()), 4'($urandom()),
                                           rand_q88(), 1'($urandom()));
          else if (pick < 96) send_request(OP_INPUT, 4'($urandom()), 4'($urandom()),
                                           rand_q88(), 1'b0);
          else send_request(3'($urandom_range(5, 7)), 4'($urandom()), 4'($urandom()),
                            16'($urandom()), 1'($urandom()));
          sent++;
        end
      end
    end

    drain_and_settle();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_dense_layer_fast_sigmoid_train_core: clean");
    end else begin
      $display("tb_dense_layer_fast_sigmoid_train_core: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dlfs_pkg.sv
src/dlfs_ctrl.sv
src/dlfs_dp.sv
src/dense_layer_fast_sigmoid_train_core.sv
verif/tb_dense_layer_fast_sigmoid_train_core.sv
